// ===== rtl/swm_pkg.sv =====
// Package for the sliding window median block: widths, codes and shared types.
// Used by every module under rtl/ except swm_ram; depends on nothing.
package swm_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int SAMPLE_W         = 16;
  localparam int DEV_W            = 17;
  localparam int MIN_W            = 7;
  localparam int MODE_W           = 2;

  localparam logic [MIN_W-1:0]  MIN_FILL_RST = 7'd16;

  localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROBE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DEL,
    CELL_INS,
    CELL_CLR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    sample_t  key;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS,
    ST_CLR,
    ST_MED,
    ST_RES
  } state_t;

endpackage

// ===== rtl/swm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/swm_cell.sv =====
// One cell of the sorted chain: holds one sample and a valid bit.
// Depends on swm_pkg (cell_cmd_t, sample_t).
module swm_cell import swm_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  sample_t          left_value,
  input  logic             left_valid,
  input  logic             left_pos,
  input  sample_t          right_value,
  input  logic             right_valid,
  input  logic [IDX_W-1:0] med_idx,
  output sample_t          value,
  output logic             valid,
  output logic             pos,
  output sample_t          med_part
);

  logic ge;
  logic gt;

  // valid cells are sorted ascending and packed at the low end, so both
  // flags below are monotonic along the chain
  assign ge  = valid && (value >= cmd.key);
  assign gt  = valid && (value > cmd.key);
  assign pos = gt || !valid;

  assign med_part = (valid && (med_idx == IDX_W'(IDX))) ? value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_DEL: begin
          if (ge) valid <= right_valid;
        end
        CELL_INS: begin
          if (pos && !left_pos) valid <= 1'b1;
          else if (pos)         valid <= left_valid;
        end
        CELL_CLR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_DEL: begin
        if (ge) value <= right_value;
      end
      CELL_INS: begin
        if (pos && !left_pos) value <= cmd.key;
        else if (pos)         value <= left_value;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/swm_chain.sv =====
// Row of sorted cells; delete shifts toward the low end, insert toward the high end.
// Depends on swm_pkg and swm_cell.
module swm_chain import swm_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int IDX_W        = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] med_idx,
  output sample_t          median
);

  sample_t value    [WINDOW_DEPTH];
  logic    valid    [WINDOW_DEPTH];
  logic    pos      [WINDOW_DEPTH];
  sample_t med_part [WINDOW_DEPTH];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    sample_t lv, rv;
    logic    lval, lpos, rval;

    if (i == 0) begin : g_first
      assign lv   = '0;
      assign lval = 1'b0;
      assign lpos = 1'b0;
    end else begin : g_mid
      assign lv   = value[i-1];
      assign lval = valid[i-1];
      assign lpos = pos[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_inner
      assign rv   = value[i+1];
      assign rval = valid[i+1];
    end

    swm_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_value  (lv),
      .left_valid  (lval),
      .left_pos    (lpos),
      .right_value (rv),
      .right_valid (rval),
      .med_idx     (med_idx),
      .value       (value[i]),
      .valid       (valid[i]),
      .pos         (pos[i]),
      .med_part    (med_part[i])
    );
  end

  // at most one cell matches the median index
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      median = median | med_part[i];
    end
  end

endmodule

// ===== rtl/sliding_window_median_baseline_core.sv =====
// Running median filter, top level: control sequencer, sample ring and sorted cell chain.
// Depends on swm_pkg, swm_ram and swm_chain.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid/in_ready, mode, sample  | in
//   result  | out_valid/out_ready, deviation,  | out
//           | median, ready_res                |
//   config  | cfg_valid/cfg_ready, cfg_data    | in
//
// An item occupies the block until its result is loaded; a probe goes straight to the
// median step, a clear or a store into a non-full window clears or inserts first, and a
// store into a full window deletes the oldest sample, read from the ring, then inserts.
// Synchronous reset empties the window and sets the fill threshold to 16.
// A result held in the output register does not block the next transaction;
// only the final step waits while that register is still occupied.
module sliding_window_median_baseline_core import swm_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [DEV_W-1:0]    deviation,
  output logic signed [SAMPLE_W-1:0] median,
  output logic                ready_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MIN_W-1:0]    cfg_data
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  state_t              state, state_next;
  logic [MODE_W-1:0]   mode_q;
  sample_t             sample_q;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    wr_pos;
  logic [MIN_W-1:0]    min_fill;
  sample_t             med_q;
  sample_t             chain_median;
  sample_t             oldest;
  cell_cmd_t           cmd;
  logic                accept;
  logic                full;
  logic                is_ready;
  logic                out_load;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full      = (count == CNT_W'(WINDOW_DEPTH));
  assign is_ready  = CMP_W'(count) >= CMP_W'(min_fill);
  assign out_load  = (state == ST_RES) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_fill <= MIN_FILL_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_fill <= cfg_data;
    end
  end

  // ring of raw samples; only needed to find the value to evict
  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_INS),
    .waddr (wr_pos),
    .wdata (sample_q),
    .re    (accept),
    .raddr (wr_pos),
    .rdata (oldest)
  );

  always_comb begin
    cmd.op  = CELL_HOLD;
    cmd.key = sample_q;
    case (state)
      ST_DEL: begin
        cmd.op  = CELL_DEL;
        cmd.key = oldest;
      end
      ST_INS: cmd.op = CELL_INS;
      ST_CLR: cmd.op = CELL_CLR;
      default: ;
    endcase
  end

  swm_chain #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .IDX_W        (IDX_W)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .med_idx (IDX_W'(count >> 1)),
    .median  (chain_median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_CLEAR)      state_next = ST_CLR;
          else if (mode == MODE_STORE) state_next = full ? ST_DEL : ST_INS;
          else                         state_next = ST_MED;
        end
      end
      ST_DEL:  state_next = ST_INS;
      ST_INS:  state_next = ST_MED;
      ST_CLR:  state_next = ST_MED;
      ST_MED:  state_next = ST_RES;
      ST_RES: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wr_pos    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_DEL: count <= count - 1'b1;
        ST_INS: begin
          count  <= count + 1'b1;
          wr_pos <= (wr_pos == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
        end
        ST_CLR: begin
          count  <= '0;
          wr_pos <= '0;
        end
        default: ;
      endcase
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      sample_q <= sample;
    end
    if (state == ST_MED) begin
      med_q <= chain_median;
    end
    if (out_load) begin
      median    <= med_q;
      ready_res <= is_ready;
      if (is_ready && mode_q != MODE_CLEAR) begin
        deviation <= DEV_W'(sample_q) - DEV_W'(med_q);
      end else begin
        deviation <= '0;
      end
    end
  end

endmodule

// ===== rtl/swm_checker.sv =====
// Port-level checks for the running median filter, bound to the top level.
// Depends on swm_pkg and sliding_window_median_baseline_core.
module swm_checker import swm_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [DEV_W-1:0]     deviation,
  input logic signed [SAMPLE_W-1:0]  median,
  input logic                        ready_res
);

  // one transaction in flight: a new one is never taken on the next edge
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ready_res |-> deviation == '0)
    else $error("nonzero deviation while not ready");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(deviation) && $stable(median)
      && $stable(ready_res))
    else $error("stalled result changed");

endmodule

bind sliding_window_median_baseline_core swm_checker u_swm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .deviation (deviation),
  .median    (median),
  .ready_res (ready_res)
);

// ===== sim/sliding_window_median_baseline_core_tb.sv =====
// Testbench for sliding_window_median_baseline_core: directed table, then random
// phases over several fill threshold settings, checked against an in-bench median predictor.
// Depends on rtl/swm_pkg.sv and the core RTL.
`timescale 1ns / 1ps

module sliding_window_median_baseline_core_tb;
  import swm_pkg::*;

  localparam int WIN        = WINDOW_DEPTH_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYC   = 300;
  localparam int TAIL_CYC   = 8;
  localparam int PHASE_LEN  = 150;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [DEV_W-1:0] dev;
    sample_t                 med;
    logic                    rdy;
  } result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [MODE_W-1:0] mode;
    int                val;
    bit                typed;
    result_t           res;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [MODE_W-1:0]          mode = MODE_STORE;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [DEV_W-1:0]    deviation;
  logic signed [SAMPLE_W-1:0] median;
  logic                       ready_res;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [MIN_W-1:0]           cfg_data = '0;

  sliding_window_median_baseline_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .deviation(deviation), .median(median), .ready_res(ready_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  sample_t          ring [WIN];
  int               wr_pos;
  int               held;
  logic [MIN_W-1:0] min_samp;

  result_t   expected_q[$];
  result_t   cur_exp = '0;
  bit        cur_typed = 1'b0;
  result_t   pred, want, got;
  int        errors = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;
  int        burst_left = 0;
  stim_row_t dir_tbl[$];

  function automatic result_t median_step(logic [MODE_W-1:0] m, sample_t s);
    result_t r;
    sample_t srt [WIN];
    sample_t v;
    int      n;
    int      j;
    int      d;
    r = '0;
    if (m == MODE_CLEAR) begin
      wr_pos = 0;
      held   = 0;
      r.rdy  = (min_samp == 0);
    end else begin
      if (m == MODE_STORE) begin
        ring[wr_pos] = s;
        wr_pos = (wr_pos + 1) % WIN;
        if (held < WIN) held++;
      end
      n = held;
      for (int i = 0; i < n; i++) begin
        v = ring[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      if (n > 0) r.med = srt[n/2];
      r.rdy = (held >= int'(min_samp));
      if (r.rdy) begin
        d = int'(s) - int'(r.med);
        r.dev = d[DEV_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic void add_row(row_kind_t k, logic [MODE_W-1:0] m, int v,
                                  bit typed = 1'b0, int dev = 0, int med = 0,
                                  bit rdy = 1'b0);
    stim_row_t row;
    row.kind      = k;
    row.mode      = m;
    row.val       = v;
    row.typed     = typed;
    row.res.dev   = dev[DEV_W-1:0];
    row.res.med   = med[SAMPLE_W-1:0];
    row.res.rdy   = rdy;
    dir_tbl.push_back(row);
  endfunction

  function automatic sample_t rand_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (pick < 50) return sample_t'($urandom_range(0, 16) - 8);
    return sample_t'($urandom);
  endfunction

  // scoreboard: predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) min_samp = cfg_data;
      if (in_valid && in_ready) begin
        pred = median_step(mode, sample);
        expected_q.push_back(cur_typed ? cur_exp : pred);
      end
      if (out_valid && out_ready) begin
        got = {deviation, median, ready_res};
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected result: dev=%0d med=%0d rdy=%0b",
                     deviation, median, ready_res);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp dev=%0d med=%0d rdy=%0b, got dev=%0d med=%0d rdy=%0b",
                       want.dev, want.med, want.rdy, deviation, median, ready_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: stall patterns in segments, plus one long hold-off on request
  initial begin
    int seg;
    int pat;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        seg = $urandom_range(4, 40);
        pat = $urandom_range(0, 3);
        for (int k = 0; k < seg; k++) begin
          case (pat)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= ((k % 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic [MODE_W-1:0] m, sample_t s, bit typed, result_t r);
    in_valid  <= 1'b1;
    mode      <= m;
    sample    <= s;
    cur_typed <= typed;
    cur_exp   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // bursts of random length with random gaps; no gaps while the sink is held off
  task automatic pace();
    if (hold_req || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // let the scoreboard log the last input transaction before checking the queue
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic write_min(logic [MIN_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [MIN_W-1:0] phase_min [8];
    logic [MODE_W-1:0] m;
    int pick;

    wr_pos   = 0;
    held     = 0;
    min_samp = MIN_FILL_RST;

    // reset threshold of 16: nothing ready yet
    add_row(ROW_ITEM, MODE_PROBE, 0,       1, 0, 0,      0);
    add_row(ROW_ITEM, MODE_STORE, -32768,  1, 0, -32768, 0);
    add_row(ROW_ITEM, MODE_STORE, 32767,   1, 0, 32767,  0); // upper median of two
    add_row(ROW_ITEM, MODE_SPARE, 5,       1, 0, 32767,  0); // spare mode acts as probe
    add_row(ROW_ITEM, MODE_CLEAR, 'h1234,  1, 0, 0,      0);
    // threshold zero: ready on an empty window
    add_row(ROW_CFG,  MODE_STORE, 0);
    add_row(ROW_ITEM, MODE_PROBE, 32767,   1, 32767,  0,      1);
    add_row(ROW_ITEM, MODE_PROBE, -32768,  1, -32768, 0,      1);
    add_row(ROW_ITEM, MODE_CLEAR, -1,      1, 0,      0,      1);
    add_row(ROW_ITEM, MODE_STORE, 32767,   1, 0,      32767,  1);
    add_row(ROW_ITEM, MODE_PROBE, -32768,  1, -65535, 32767,  1);
    add_row(ROW_ITEM, MODE_STORE, -32768,  1, -65535, 32767,  1);
    add_row(ROW_ITEM, MODE_STORE, -32768,  1, 0,      -32768, 1);
    add_row(ROW_ITEM, MODE_PROBE, 32767,   1, 65535,  -32768, 1);
    // threshold above depth: never ready
    add_row(ROW_CFG,  MODE_STORE, 127);
    add_row(ROW_ITEM, MODE_STORE, 100);
    add_row(ROW_ITEM, MODE_PROBE, -7);
    add_row(ROW_ITEM, MODE_CLEAR, 0,       1, 0, 0, 0);
    add_row(ROW_CFG,  MODE_STORE, 2);
    add_row(ROW_ITEM, MODE_STORE, 3);
    add_row(ROW_ITEM, MODE_STORE, -3);
    add_row(ROW_ITEM, MODE_SPARE, 10);

    phase_min = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd33, 7'd16, 7'd65, 7'd0};
    phase_min[7] = MIN_W'($urandom_range(0, 127));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG)
        write_min(dir_tbl[i].val[MIN_W-1:0]);
      else
        send_item(dir_tbl[i].mode, dir_tbl[i].val[SAMPLE_W-1:0], dir_tbl[i].typed,
                  dir_tbl[i].res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_min(phase_min[ph]);
      if (ph == 1) hold_req = 1'b1;  // back up the result side while inputs keep coming
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 199);
        if (pick == 0)      m = MODE_CLEAR;
        else if (pick < 9)  m = MODE_SPARE;
        else if (pick < 55) m = MODE_PROBE;
        else                m = MODE_STORE;
        send_item(m, rand_sample(), 1'b0, '0);
        pace();
      end
    end

    drain();
    if (errors == 0 && expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
